### hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

### hdl/bcdrtc_pkg.sv
// ----------------------------------------------------------------------------
// BCD RTC package
// Calendar types, request and event codes, and BCD counting helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdrtc_pkg;

  localparam int CfgWidth = 24;
  localparam int CfgIdxWidth = 3;

  // Request kinds.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_EVAL  = 2'd2;

  // Interrupt evaluation causes.
  localparam logic [1:0] EV_CARRY = 2'd0;
  localparam logic [1:0] EV_TICK  = 2'd1;
  localparam logic [1:0] EV_CFG   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HOUR24   = 3'd0;
  localparam logic [2:0] CFG_INT1     = 3'd1;
  localparam logic [2:0] CFG_INT2EN   = 3'd2;
  localparam logic [2:0] CFG_A1TIME   = 3'd3;
  localparam logic [2:0] CFG_A2TIME   = 3'd4;
  localparam logic [2:0] CFG_A1DATE   = 3'd5;
  localparam logic [2:0] CFG_A2DATE   = 3'd6;
  localparam logic [2:0] CFG_DATEEN   = 3'd7;

  // Field indexes for date/time writes.
  localparam logic [2:0] FLD_YEAR   = 3'd1;
  localparam logic [2:0] FLD_MONTH  = 3'd2;
  localparam logic [2:0] FLD_DAY    = 3'd3;
  localparam logic [2:0] FLD_WDAY   = 3'd4;
  localparam logic [2:0] FLD_HOUR   = 3'd5;
  localparam logic [2:0] FLD_MINUTE = 3'd6;
  localparam logic [2:0] FLD_SECOND = 3'd7;

  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] wday;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } cal_t;

  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] r;
    r = v + 8'd1;
    if (r[3:0] >= 4'hA) r = r + 8'h06;
    if (r[7:4] >= 4'hA) r = r + 8'h60;
    return r;
  endfunction

  function automatic logic [7:0] bcd_clean(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [7:0] r;
    r = v;
    if (v < lo || v > hi || v[3:0] >= 4'hA || v[7:4] >= 4'hA) r = lo;
    return r;
  endfunction

  function automatic logic [7:0] month_len(input cal_t c);
    logic [1:0] y4;
    logic [7:0] r;
    // Year mod 4 from BCD digits: ten times the tens digit is twice it mod 4.
    y4 = {c.year[4], 1'b0} + c.year[1:0];
    case (c.month)
      8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12: r = 8'h31;
      8'h04, 8'h06, 8'h09, 8'h11: r = 8'h30;
      8'h02: r = (y4 != 2'd0) ? 8'h28 : 8'h29;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic cal_t month_end(input cal_t c);
    cal_t r;
    r = c;
    if (r.day > month_len(c)) begin
      r.day = 8'h01;
      r.month = bcd_inc(r.month);
      if (r.month > 8'h12) begin
        r.month = 8'h01;
        r.year = bcd_inc(r.year);
      end
    end
    return r;
  endfunction

  function automatic cal_t day_step(input cal_t c);
    cal_t r;
    r = c;
    r.wday = r.wday + 8'd1;
    if (r.wday >= 8'd7) r.wday = 8'd0;
    r.day = bcd_inc(r.day);
    return month_end(r);
  endfunction

  function automatic cal_t hour_step(input cal_t c, input logic mode24);
    cal_t r;
    logic [7:0] h;
    logic [7:0] pm;
    r = c;
    h = bcd_inc({2'b00, c.hour[5:0]});
    pm = {1'b0, c.hour[6], 6'd0};
    if (mode24) begin
      if (h >= 8'h24) begin
        h = 8'h00;
        r = day_step(r);
      end
      pm = (h >= 8'h12) ? 8'h40 : 8'h00;
    end else if (h >= 8'h12) begin
      h = 8'h00;
      if (pm != 8'h00) r = day_step(r);
      pm = pm ^ 8'h40;
    end
    r.hour = h | pm;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/bcd_calendar_rtc_with_alarms.sv
// The calendar cascade is a single short combinational pass into the output register.
// Throughput: one item per cycle while the output register is empty or being emptied.
// A new beat is taken while a result waits, as long as the output register is being emptied.
// Reset (synchronous, active high) sets 2000-01-01 weekday 0 00:00:00, clears the
// subsecond and minute counters, the interrupt flags and all configuration registers.
`default_nettype none

// ----------------------------------------------------------------------------
// BCD calendar RTC with alarms
// Keeps a BCD date and time, a subsecond and minute counter, and drives two
// interrupt flags from frequency, minute and alarm sources.
// ----------------------------------------------------------------------------
module bcd_calendar_rtc_with_alarms (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bcdrtc_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [bcdrtc_pkg::CfgWidth-1:0]     cfg_data,
  input  wire logic                                req_valid,
  output logic                                     req_ready,
  input  wire logic [1:0]                          req_type,
  input  wire logic [2:0]                          field_index,
  input  wire logic [7:0]                          field_value,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_ready,
  output logic [7:0]                               year_bcd,
  output logic [4:0]                               month_bcd,
  output logic [5:0]                               day_bcd,
  output logic [2:0]                               weekday,
  output logic [6:0]                               hour_bcd,
  output logic [6:0]                               minute_bcd,
  output logic [6:0]                               second_bcd,
  output logic                                     minute_carry,
  output logic                                     int1_level,
  output logic                                     int2_level,
  output logic                                     irq_request,
  output logic [23:0]                              minute_total
);

  // Configuration registers.
  logic        hour24;
  logic [3:0]  int1_mode;
  logic        int2_en;
  logic [23:0] a1_time;
  logic [23:0] a2_time;
  logic [23:0] a1_date;
  logic [23:0] a2_date;
  logic        date_en;

  // Clock state.
  bcdrtc_pkg::cal_t cal;
  bcdrtc_pkg::cal_t cal_next;
  logic [14:0] subsec;
  logic [14:0] subsec_next;
  logic [23:0] mcount;
  logic [23:0] mcount_next;
  logic [2:0]  flags;
  logic [2:0]  flags_next;
  logic        pulse_next;

  logic accept;

  function automatic logic alarm_match(input logic [23:0] tw, input logic [23:0] dw,
                                       input bcdrtc_pkg::cal_t c, input logic den);
    logic m;
    m = 1'b1;
    if (tw[7]  && ({5'd0, tw[2:0]} != c.wday)) m = 1'b0;
    if (tw[15] && ({1'b0, tw[14:8]} != c.hour)) m = 1'b0;
    if (tw[23] && ({1'b0, tw[22:16]} != c.minute)) m = 1'b0;
    if (den) begin
      if (dw[14] && (dw[7:0] != c.year)) m = 1'b0;
      if (dw[15] && ({3'd0, dw[12:8]} != c.month)) m = 1'b0;
      if (dw[23] && ({2'd0, dw[21:16]} != c.day)) m = 1'b0;
    end
    return m;
  endfunction

  // Returns {pulse, flags}. A pulse marks INT1 or INT2 rising from both clear.
  function automatic logic [3:0] evaluate(input logic [1:0] kind, input logic [2:0] f_in,
                                          input logic [14:0] cc,
                                          input bcdrtc_pkg::cal_t c);
    logic [2:0]  f;
    logic        p;
    logic        carry_seen;
    logic [14:0] mask;
    logic        m1;
    logic        m2;
    logic        raise1;
    logic        drop1;
    logic        raise2;
    logic        drop2;
    f = f_in;
    p = 1'b0;
    raise1 = 1'b0;
    drop1 = 1'b0;
    raise2 = 1'b0;
    drop2 = 1'b0;
    carry_seen = (kind == bcdrtc_pkg::EV_CARRY) || (kind == bcdrtc_pkg::EV_CFG && f[0]);
    mask = {a1_time[16], a1_time[17], a1_time[18], a1_time[19], a1_time[20], 10'd0};
    m1 = alarm_match(a1_time, a1_date, c, date_en);
    m2 = alarm_match(a2_time, a2_date, c, date_en);
    case (int1_mode)
      4'd0: drop1 = (kind == bcdrtc_pkg::EV_CFG);
      4'd1, 4'd5: begin
        if ((kind == bcdrtc_pkg::EV_TICK && cc[9:0] == 10'd0) || kind == bcdrtc_pkg::EV_CFG) begin
          if (mask != 15'd0 && (cc & mask) != mask) raise1 = 1'b1;
          else drop1 = 1'b1;
        end
      end
      4'd2, 4'd6: raise1 = carry_seen;
      4'd3: begin
        if (carry_seen) raise1 = 1'b1;
        else drop1 = (kind == bcdrtc_pkg::EV_TICK && c.second == 8'h30 && cc == 15'd0);
      end
      4'd7: begin
        if (carry_seen) raise1 = 1'b1;
        else drop1 = (kind == bcdrtc_pkg::EV_TICK && c.second == 8'h00 && cc == 15'd256);
      end
      4'd4: begin
        if (kind == bcdrtc_pkg::EV_CARRY) begin
          raise1 = m1;
          drop1 = !m1;
        end
      end
      default: begin
        // The 32 kHz pulse sets and clears INT1 within the same tick.
        if (kind == bcdrtc_pkg::EV_TICK) begin
          raise1 = 1'b1;
          drop1 = 1'b1;
        end
      end
    endcase
    if (raise1) begin
      if (f[2:1] == 2'b00) p = 1'b1;
      f[1] = 1'b1;
    end
    if (drop1) f[1] = 1'b0;

    if (int2_en) begin
      if (kind == bcdrtc_pkg::EV_CARRY) begin
        raise2 = m2;
        drop2 = !m2;
      end
    end else begin
      drop2 = (kind == bcdrtc_pkg::EV_CFG);
    end
    if (raise2) begin
      if (f[2:1] == 2'b00) p = 1'b1;
      f[2] = 1'b1;
    end
    if (drop2) f[2] = 1'b0;
    return {p, f};
  endfunction

  always_comb begin
    logic [3:0] ev;
    cal_next = cal;
    subsec_next = subsec;
    mcount_next = mcount;
    flags_next = flags;
    pulse_next = 1'b0;
    ev = 4'd0;
    case (req_type)
      bcdrtc_pkg::REQ_TICK: begin
        subsec_next = subsec + 15'd1;
        if (subsec_next == 15'd0) begin
          cal_next.second = bcdrtc_pkg::bcd_inc(cal.second);
          if (cal_next.second >= 8'h60) begin
            cal_next.second = 8'h00;
            mcount_next = mcount + 24'd1;
            cal_next.minute = bcdrtc_pkg::bcd_inc(cal.minute);
            if (cal_next.minute >= 8'h60) begin
              cal_next.minute = 8'h00;
              cal_next = bcdrtc_pkg::hour_step(cal_next, hour24);
            end
            flags_next[0] = 1'b1;
            ev = evaluate(bcdrtc_pkg::EV_CARRY, flags_next, subsec_next, cal_next);
            flags_next = ev[2:0];
            pulse_next = ev[3];
          end
        end else if (subsec_next == 15'd4) begin
          flags_next[0] = 1'b0;
        end
        ev = evaluate(bcdrtc_pkg::EV_TICK, flags_next, subsec_next, cal_next);
        flags_next = ev[2:0];
        pulse_next = pulse_next | ev[3];
      end
      bcdrtc_pkg::REQ_WRITE: begin
        case (field_index)
          bcdrtc_pkg::FLD_YEAR:
            cal_next.year = bcdrtc_pkg::bcd_clean(field_value, 8'h00, 8'h99);
          bcdrtc_pkg::FLD_MONTH:
            cal_next.month = bcdrtc_pkg::bcd_clean({3'd0, field_value[4:0]}, 8'h01, 8'h12);
          bcdrtc_pkg::FLD_DAY: begin
            cal_next.day = bcdrtc_pkg::bcd_clean({2'd0, field_value[5:0]}, 8'h01, 8'h31);
            cal_next = bcdrtc_pkg::month_end(cal_next);
          end
          bcdrtc_pkg::FLD_WDAY:
            cal_next.wday = bcdrtc_pkg::bcd_clean({5'd0, field_value[2:0]}, 8'h00, 8'h06);
          bcdrtc_pkg::FLD_HOUR: begin
            if (hour24) begin
              cal_next.hour = bcdrtc_pkg::bcd_clean({2'd0, field_value[5:0]}, 8'h00, 8'h23);
              if (cal_next.hour >= 8'h12) cal_next.hour[6] = 1'b1;
            end else begin
              cal_next.hour = bcdrtc_pkg::bcd_clean({2'd0, field_value[5:0]}, 8'h00, 8'h11);
              cal_next.hour[6] = field_value[6];
            end
          end
          bcdrtc_pkg::FLD_MINUTE:
            cal_next.minute = bcdrtc_pkg::bcd_clean({1'b0, field_value[6:0]}, 8'h00, 8'h59);
          bcdrtc_pkg::FLD_SECOND:
            cal_next.second = bcdrtc_pkg::bcd_clean({1'b0, field_value[6:0]}, 8'h00, 8'h59);
          default: ;
        endcase
      end
      bcdrtc_pkg::REQ_EVAL: begin
        ev = evaluate(bcdrtc_pkg::EV_CFG, flags, subsec, cal);
        flags_next = ev[2:0];
        pulse_next = ev[3];
      end
      default: ;
    endcase
  end

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hour24 <= 1'b0;
      int1_mode <= 4'd0;
      int2_en <= 1'b0;
      a1_time <= 24'd0;
      a2_time <= 24'd0;
      a1_date <= 24'd0;
      a2_date <= 24'd0;
      date_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcdrtc_pkg::CFG_HOUR24: hour24 <= cfg_data[0];
        bcdrtc_pkg::CFG_INT1:   int1_mode <= cfg_data[3:0];
        bcdrtc_pkg::CFG_INT2EN: int2_en <= cfg_data[0];
        bcdrtc_pkg::CFG_A1TIME: a1_time <= cfg_data;
        bcdrtc_pkg::CFG_A2TIME: a2_time <= cfg_data;
        bcdrtc_pkg::CFG_A1DATE: a1_date <= cfg_data;
        bcdrtc_pkg::CFG_A2DATE: a2_date <= cfg_data;
        bcdrtc_pkg::CFG_DATEEN: date_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '{year: 8'h00, month: 8'h01, day: 8'h01, wday: 8'h00,
               hour: 8'h00, minute: 8'h00, second: 8'h00};
      subsec <= 15'd0;
      mcount <= 24'd0;
      flags <= 3'd0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cal <= cal_next;
        subsec <= subsec_next;
        mcount <= mcount_next;
        flags <= flags_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      year_bcd <= cal_next.year;
      month_bcd <= cal_next.month[4:0];
      day_bcd <= cal_next.day[5:0];
      weekday <= cal_next.wday[2:0];
      hour_bcd <= cal_next.hour[6:0];
      minute_bcd <= cal_next.minute[6:0];
      second_bcd <= cal_next.second[6:0];
      minute_carry <= flags_next[0];
      int1_level <= flags_next[1];
      int2_level <= flags_next[2];
      irq_request <= pulse_next;
      minute_total <= mcount_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_irq_source, clk, rst, rsp_valid && irq_request, int1_level || int2_level || int1_mode[3], "irq_request without a set interrupt flag")
  `ASSERT_NEXT(a_minute_step, clk, rst, accept, (mcount == $past(mcount)) || (mcount == $past(mcount) + 24'd1), "minute counter moved by more than one")
  `ASSERT_IMPLY(a_month_range, clk, rst, 1'b1, cal.month >= 8'h01 && cal.month <= 8'h12, "month register out of range")

endmodule

`default_nettype wire

### tb/tb_bcd_calendar_rtc_with_alarms.sv
// ----------------------------------------------------------------------------
// BCD calendar RTC testbench
// Drives tick, field-write, re-evaluation and undefined-kind beats with random
// gaps and stalls, predicts every result with an independent calendar model and
// compares each field of each returned result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bcd_calendar_rtc_with_alarms;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] kind;
    logic [2:0] idx;
    logic [7:0] val;
  } rtc_beat_t;

  typedef struct {
    logic [7:0]  year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [2:0]  wday;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        carry;
    logic        int1;
    logic        int2;
    logic        irq;
    logic [23:0] minutes;
  } rtc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bcdrtc_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [bcdrtc_pkg::CfgWidth-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] req_type = '0;
  logic [2:0] field_index = '0;
  logic [7:0] field_value = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [7:0] year_bcd;
  logic [4:0] month_bcd;
  logic [5:0] day_bcd;
  logic [2:0] weekday;
  logic [6:0] hour_bcd, minute_bcd, second_bcd;
  logic minute_carry, int1_level, int2_level, irq_request;
  logic [23:0] minute_total;

  bcd_calendar_rtc_with_alarms dut (.*);

  always #5 clk = ~clk;

  // Calendar model: year, month, day, weekday, hour, minute, second.
  logic [7:0]  cal [7];
  logic [14:0] sub_count;
  logic [23:0] minute_count;
  logic        carry_flag, int1_flag, int2_flag, irq_seen;
  logic        m_hour24, m_int2en, m_dateen;
  logic [3:0]  m_int1mode;
  logic [23:0] m_a1time, m_a2time, m_a1date, m_a2date;

  rtc_beat_t   pending_beats[$];
  rtc_result_t expected_results[$];
  int          errors = 0;
  bit          steady = 1'b0;
  bit          beat_taken = 1'b0;
  bit          result_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;

  function automatic logic [7:0] bcd_next(input logic [7:0] v);
    logic [7:0] r;
    r = v + 8'd1;
    if (r[3:0] > 4'd9) r = r + 8'h06;
    if (r[7:4] > 4'd9) r = r + 8'h60;
    return r;
  endfunction

  function automatic logic [7:0] bcd_sane(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
    if (v < lo || v > hi || v[3:0] > 4'd9 || v[7:4] > 4'd9) return lo;
    return v;
  endfunction

  function automatic logic [7:0] days_in_month();
    int y;
    case (cal[1])
      8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12: return 8'h31;
      8'h04, 8'h06, 8'h09, 8'h11: return 8'h30;
      8'h02: begin
        y = cal[0][3:0] + 10 * cal[0][7:4];
        return (y % 4 != 0) ? 8'h28 : 8'h29;
      end
      default: return 8'h00;
    endcase
  endfunction

  function automatic void roll_month();
    if (cal[2] > days_in_month()) begin
      cal[2] = 8'h01;
      cal[1] = bcd_next(cal[1]);
      if (cal[1] > 8'h12) begin
        cal[1] = 8'h01;
        cal[0] = bcd_next(cal[0]);
      end
    end
  endfunction

  function automatic void next_day();
    cal[3] = (cal[3] + 8'd1 >= 8'd7) ? 8'd0 : cal[3] + 8'd1;
    cal[2] = bcd_next(cal[2]);
    roll_month();
  endfunction

  function automatic void next_hour();
    logic [7:0] h, pm;
    h = bcd_next({2'b00, cal[4][5:0]});
    pm = cal[4] & 8'h40;
    if (m_hour24) begin
      if (h >= 8'h24) begin
        h = 8'h00;
        next_day();
      end
      pm = (h >= 8'h12) ? 8'h40 : 8'h00;
    end else if (h >= 8'h12) begin
      h = 8'h00;
      if (pm != 8'h00) next_day();
      pm = pm ^ 8'h40;
    end
    cal[4] = h | pm;
  endfunction

  // INT1 or INT2 rising while both were clear gives the request pulse.
  function automatic void set_int(input bit second_line);
    logic was;
    was = int1_flag | int2_flag;
    if (second_line) int2_flag = 1'b1;
    else int1_flag = 1'b1;
    if (!was) irq_seen = 1'b1;
  endfunction

  function automatic bit alarm_hit(input logic [23:0] tw, input logic [23:0] dw);
    bit ok;
    ok = 1'b1;
    if (tw[7]) ok &= ({5'd0, tw[2:0]} == cal[3]);
    if (tw[15]) ok &= ({1'b0, tw[14:8]} == cal[4]);
    if (tw[23]) ok &= ({1'b0, tw[22:16]} == cal[5]);
    if (m_dateen) begin
      if (dw[14]) ok &= (dw[7:0] == cal[0]);
      if (dw[15]) ok &= ({3'd0, dw[12:8]} == cal[1]);
      if (dw[23]) ok &= ({2'd0, dw[21:16]} == cal[2]);
    end
    return ok;
  endfunction

  function automatic void rate_int(input logic [1:0] cause);
    bit saw_carry;
    logic [14:0] mask;
    saw_carry = (cause == bcdrtc_pkg::EV_CARRY) ||
                (cause == bcdrtc_pkg::EV_CFG && carry_flag);
    case (m_int1mode)
      4'd0: if (cause == bcdrtc_pkg::EV_CFG) int1_flag = 1'b0;
      4'd1, 4'd5: begin
        if ((cause == bcdrtc_pkg::EV_TICK && sub_count[9:0] == 10'd0) ||
            cause == bcdrtc_pkg::EV_CFG) begin
          mask = {m_a1time[16], m_a1time[17], m_a1time[18], m_a1time[19], m_a1time[20],
                  10'd0};
          if (mask != 15'd0 && (sub_count & mask) != mask) set_int(1'b0);
          else int1_flag = 1'b0;
        end
      end
      4'd2, 4'd6: if (saw_carry) set_int(1'b0);
      4'd3: begin
        if (saw_carry) set_int(1'b0);
        else if (cause == bcdrtc_pkg::EV_TICK && cal[6] == 8'h30 && sub_count == 15'd0)
          int1_flag = 1'b0;
      end
      4'd7: begin
        if (saw_carry) set_int(1'b0);
        else if (cause == bcdrtc_pkg::EV_TICK && cal[6] == 8'h00 && sub_count == 15'd256)
          int1_flag = 1'b0;
      end
      4'd4: begin
        if (cause == bcdrtc_pkg::EV_CARRY) begin
          if (alarm_hit(m_a1time, m_a1date)) set_int(1'b0);
          else int1_flag = 1'b0;
        end
      end
      default: begin
        if (cause == bcdrtc_pkg::EV_TICK) begin
          set_int(1'b0);
          int1_flag = 1'b0;
        end
      end
    endcase
    if (m_int2en) begin
      if (cause == bcdrtc_pkg::EV_CARRY) begin
        if (alarm_hit(m_a2time, m_a2date)) set_int(1'b1);
        else int2_flag = 1'b0;
      end
    end else if (cause == bcdrtc_pkg::EV_CFG) begin
      int2_flag = 1'b0;
    end
  endfunction

  function automatic void advance_tick();
    sub_count = sub_count + 15'd1;
    if (sub_count == 15'd0) begin
      cal[6] = bcd_next(cal[6]);
      if (cal[6] >= 8'h60) begin
        cal[6] = 8'h00;
        minute_count = minute_count + 24'd1;
        cal[5] = bcd_next(cal[5]);
        if (cal[5] >= 8'h60) begin
          cal[5] = 8'h00;
          next_hour();
        end
        carry_flag = 1'b1;
        rate_int(bcdrtc_pkg::EV_CARRY);
      end
    end else if (sub_count == 15'd4) begin
      carry_flag = 1'b0;
    end
    rate_int(bcdrtc_pkg::EV_TICK);
  endfunction

  function automatic void store_field(input logic [2:0] idx, input logic [7:0] v);
    logic [7:0] h, pm;
    case (idx)
      bcdrtc_pkg::FLD_YEAR:   cal[0] = bcd_sane(v, 8'h00, 8'h99);
      bcdrtc_pkg::FLD_MONTH:  cal[1] = bcd_sane(v & 8'h1F, 8'h01, 8'h12);
      bcdrtc_pkg::FLD_DAY: begin
        cal[2] = bcd_sane(v & 8'h3F, 8'h01, 8'h31);
        roll_month();
      end
      bcdrtc_pkg::FLD_WDAY:   cal[3] = bcd_sane(v & 8'h07, 8'h00, 8'h06);
      bcdrtc_pkg::FLD_HOUR: begin
        h = v & 8'h3F;
        pm = v & 8'h40;
        if (m_hour24) begin
          h = bcd_sane(h, 8'h00, 8'h23);
          pm = (h >= 8'h12) ? 8'h40 : 8'h00;
        end else begin
          h = bcd_sane(h, 8'h00, 8'h11);
        end
        cal[4] = h | pm;
      end
      bcdrtc_pkg::FLD_MINUTE: cal[5] = bcd_sane(v & 8'h7F, 8'h00, 8'h59);
      bcdrtc_pkg::FLD_SECOND: cal[6] = bcd_sane(v & 8'h7F, 8'h00, 8'h59);
      default: ;
    endcase
  endfunction

  function automatic rtc_result_t predict_rtc(input rtc_beat_t b);
    rtc_result_t r;
    irq_seen = 1'b0;
    if (b.kind == bcdrtc_pkg::REQ_TICK) advance_tick();
    else if (b.kind == bcdrtc_pkg::REQ_WRITE) store_field(b.idx, b.val);
    else if (b.kind == bcdrtc_pkg::REQ_EVAL) rate_int(bcdrtc_pkg::EV_CFG);
    r.year = cal[0];
    r.month = cal[1][4:0];
    r.day = cal[2][5:0];
    r.wday = cal[3][2:0];
    r.hour = cal[4][6:0];
    r.minute = cal[5][6:0];
    r.second = cal[6][6:0];
    r.carry = carry_flag;
    r.int1 = int1_flag;
    r.int2 = int2_flag;
    r.irq = irq_seen;
    r.minutes = minute_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endfunction

  // Beat acceptance: the model advances as each beat is taken.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      expected_results.push_back(predict_rtc('{req_type, field_index, field_value}));
      beat_taken = 1'b1;
    end
  end

  always @(posedge clk) begin
    rtc_result_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      result_taken = 1'b1;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual hour %h", $realtime, hour_bcd);
      end else begin
        e = expected_results.pop_front();
        check_field("year", 24'(e.year), 24'(year_bcd));
        check_field("month", 24'(e.month), 24'(month_bcd));
        check_field("day", 24'(e.day), 24'(day_bcd));
        check_field("weekday", 24'(e.wday), 24'(weekday));
        check_field("hour", 24'(e.hour), 24'(hour_bcd));
        check_field("minute", 24'(e.minute), 24'(minute_bcd));
        check_field("second", 24'(e.second), 24'(second_bcd));
        check_field("minute_carry", 24'(e.carry), 24'(minute_carry));
        check_field("int1_level", 24'(e.int1), 24'(int1_level));
        check_field("int2_level", 24'(e.int2), 24'(int2_level));
        check_field("irq_request", 24'(e.irq), 24'(irq_request));
        check_field("minute_total", e.minutes, minute_total);
      end
    end
  end

  // Request driver: a gap is drawn after every beat.
  always @(negedge clk) begin
    rtc_beat_t b;
    if (!rst && !(req_valid && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        req_type <= b.kind;
        field_index <= b.idx;
        field_value <= b.val;
        req_valid <= 1'b1;
        gap_left = steady ? 0 : $urandom_range(0, 13);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) begin
        result_taken = 1'b0;
        stall_left = steady ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic add_beat(input logic [1:0] kind, input logic [2:0] idx, input logic [7:0] v);
    pending_beats.push_back('{kind, idx, v});
  endtask

  // Waits until every beat is taken and every result has returned, checking at
  // clock edges so that a beat just popped by the driver is still seen.
  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      bcdrtc_pkg::CFG_HOUR24: m_hour24 = v[0];
      bcdrtc_pkg::CFG_INT1:   m_int1mode = v[3:0];
      bcdrtc_pkg::CFG_INT2EN: m_int2en = v[0];
      bcdrtc_pkg::CFG_A1TIME: m_a1time = v;
      bcdrtc_pkg::CFG_A2TIME: m_a2time = v;
      bcdrtc_pkg::CFG_A1DATE: m_a1date = v;
      bcdrtc_pkg::CFG_A2DATE: m_a2date = v;
      bcdrtc_pkg::CFG_DATEEN: m_dateen = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_clock(input logic [7:0] y, input logic [7:0] mo, input logic [7:0] d,
                           input logic [7:0] h, input logic [7:0] mi, input logic [7:0] s);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_YEAR, y);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_MONTH, mo);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_DAY, d);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_HOUR, h);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_MINUTE, mi);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_SECOND, s);
    add_beat(bcdrtc_pkg::REQ_EVAL, bcdrtc_pkg::FLD_YEAR, 8'h00);
    drain();
  endtask

  // Runs a burst of ticks back to back.
  task automatic tick_burst(input int n);
    steady = 1'b1;
    repeat (n) add_beat(bcdrtc_pkg::REQ_TICK, 3'd0, 8'($urandom));
    drain();
    steady = 1'b0;
  endtask

  initial begin
    rtc_beat_t b;
    int r;
    cal = '{8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    sub_count = '0;
    minute_count = '0;
    {carry_flag, int1_flag, int2_flag, irq_seen} = '0;
    {m_hour24, m_int2en, m_dateen} = '0;
    m_int1mode = '0;
    {m_a1time, m_a2time, m_a1date, m_a2date} = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Field extremes, invalid values and odd request kinds in 12-hour mode.
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_YEAR, 8'h99);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_YEAR, 8'hFF);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_YEAR, 8'h9A);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_MONTH, 8'h13);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_MONTH, 8'h04);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_DAY, 8'h31);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_DAY, 8'h00);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_WDAY, 8'h06);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_WDAY, 8'h07);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_HOUR, 8'h51);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_HOUR, 8'h12);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_MINUTE, 8'h59);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_MINUTE, 8'h5A);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_SECOND, 8'hFF);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_SECOND, 8'h59);
    add_beat(bcdrtc_pkg::REQ_WRITE, 3'd0, 8'h55);
    add_beat(2'd3, bcdrtc_pkg::FLD_YEAR, 8'h11);
    add_beat(bcdrtc_pkg::REQ_EVAL, bcdrtc_pkg::FLD_DAY, 8'h00);
    add_beat(bcdrtc_pkg::REQ_TICK, 3'd0, 8'h00);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_HOUR, 8'hFF);
    drain();

    // A day write past the end of a non-leap February, with INT2 on alarm 2.
    write_reg(bcdrtc_pkg::CFG_INT1, 24'd2);
    write_reg(bcdrtc_pkg::CFG_INT2EN, 24'd1);
    write_reg(bcdrtc_pkg::CFG_A2TIME, 24'h808081);
    set_clock(8'h23, 8'h02, 8'h29, 8'h51, 8'h59, 8'h59);
    tick_burst(8);

    // 24-hour mode, leap day, date alarm on INT1.
    write_reg(bcdrtc_pkg::CFG_HOUR24, 24'd1);
    write_reg(bcdrtc_pkg::CFG_DATEEN, 24'd1);
    write_reg(bcdrtc_pkg::CFG_INT1, 24'd4);
    write_reg(bcdrtc_pkg::CFG_A1TIME, 24'h800000);
    write_reg(bcdrtc_pkg::CFG_A1DATE, 24'h29C224);
    write_reg(bcdrtc_pkg::CFG_A2DATE, 24'hBF40FF);
    set_clock(8'h24, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59);
    tick_burst(8);

    // End of century, then the 256-tick duty mode carried past its clearing tick.
    write_reg(bcdrtc_pkg::CFG_INT1, 24'd7);
    write_reg(bcdrtc_pkg::CFG_DATEEN, 24'd0);
    set_clock(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h00);
    tick_burst(260 - int'(sub_count));

    // Minute-steady mode cleared at half past.
    write_reg(bcdrtc_pkg::CFG_INT1, 24'd3);
    set_clock(8'h10, 8'h06, 8'h30, 8'h05, 8'h10, 8'h59);
    tick_burst(4);
    add_beat(bcdrtc_pkg::REQ_WRITE, bcdrtc_pkg::FLD_SECOND, 8'h29);
    drain();
    tick_burst(4);

    // Frequency-steady output raised on re-evaluation, then the pulse mode.
    write_reg(bcdrtc_pkg::CFG_INT1, 24'd5);
    write_reg(bcdrtc_pkg::CFG_A1TIME, 24'h1F0000);
    write_reg(bcdrtc_pkg::CFG_INT2EN, 24'd0);
    add_beat(bcdrtc_pkg::REQ_EVAL, 3'd0, 8'h00);
    drain();
    tick_burst(4);
    write_reg(bcdrtc_pkg::CFG_INT1, 24'd15);
    repeat (10) add_beat(bcdrtc_pkg::REQ_TICK, 3'd0, 8'h00);
    drain();

    // Random beats under random settings, mostly ticks and field writes.
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(bcdrtc_pkg::CFG_HOUR24, 24'(1'($urandom)));
      write_reg(bcdrtc_pkg::CFG_INT1,
                (phase == 0) ? 24'd0 : (phase == 1) ? 24'd15 : 24'(4'($urandom)));
      write_reg(bcdrtc_pkg::CFG_INT2EN, 24'(1'($urandom)));
      write_reg(bcdrtc_pkg::CFG_A1TIME, (phase == 0) ? 24'hFFFFFF : 24'($urandom));
      write_reg(bcdrtc_pkg::CFG_A2TIME, (phase == 0) ? 24'h000000 : 24'($urandom));
      write_reg(bcdrtc_pkg::CFG_A1DATE, (phase == 1) ? 24'hFFFFFF : 24'($urandom));
      write_reg(bcdrtc_pkg::CFG_A2DATE, (phase == 1) ? 24'h000000 : 24'($urandom));
      write_reg(bcdrtc_pkg::CFG_DATEEN, 24'(1'($urandom)));
      for (int i = 0; i < 14; i++) begin
        r = $urandom_range(0, 99);
        b.kind = (r < 50) ? bcdrtc_pkg::REQ_TICK : (r < 85) ? bcdrtc_pkg::REQ_WRITE :
                 (r < 95) ? bcdrtc_pkg::REQ_EVAL : 2'd3;
        b.idx = 3'($urandom);
        b.val = 8'($urandom);
        pending_beats.push_back(b);
      end
      drain();
    end

    repeat (5) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
